// ===== rtl/spq_pkg.sv =====
// Shared types, widths and codes for the stable priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int VALUE_W        = 32;
  localparam int PRIO_W         = 8;
  localparam int OPC_W          = 2;
  localparam int STAT_W         = 2;
  localparam int CAPACITY_DEF   = 16;
  localparam int PRIO_BITS_DEF  = 8;
  localparam int CNT_W_DEF      = $clog2(CAPACITY_DEF + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2
  } spq_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_in_if.sv =====
// Operation channel: valid/ready with opcode, value and priority.
`timescale 1ns / 1ps
interface spq_in_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPC_W-1:0]    opcode;
  logic [VALUE_W-1:0]  value;
  logic [PRIO_W-1:0]   prio;

  modport source (output valid, output opcode, output value, output prio, input ready);
  modport sink   (input valid, input opcode, input value, input prio, output ready);
endinterface

// ===== rtl/spq_out_if.sv =====
// Result channel: valid/ready with status and queue snapshot.
`timescale 1ns / 1ps
interface spq_out_if #(
  parameter int CNT_W = spq_pkg::CNT_W_DEF
);
  import spq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STAT_W-1:0]          status;
  logic [CNT_W-1:0]           count;
  logic                       is_empty;
  logic signed [VALUE_W-1:0]  head_value;
  logic [PRIO_W-1:0]          head_prio;
  logic signed [VALUE_W-1:0]  tail_value;
  logic [PRIO_W-1:0]          tail_prio;

  modport source (output valid, output status, output count, output is_empty,
                  output head_value, output head_prio, output tail_value,
                  output tail_prio, input ready);
  modport sink   (input valid, input status, input count, input is_empty,
                  input head_value, input head_prio, input tail_value,
                  input tail_prio, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps
module spq_cell #(
  parameter int PW = spq_pkg::PRIO_BITS_DEF
) (
  input  logic                         clk,
  input  spq_pkg::spq_cmd_t            cmd,
  input  logic                         occ_self,
  input  logic                         occ_left,
  input  logic [spq_pkg::VALUE_W-1:0]  new_value,
  input  logic [PW-1:0]                new_prio,
  input  logic [spq_pkg::VALUE_W-1:0]  left_value,
  input  logic [PW-1:0]                left_prio,
  input  logic [spq_pkg::VALUE_W-1:0]  right_value,
  input  logic [PW-1:0]                right_prio,
  output logic [spq_pkg::VALUE_W-1:0]  value,
  output logic [PW-1:0]                prio
);
  import spq_pkg::*;

  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [PW-1:0]      prio_r, prio_nxt;
  logic               keep_self;
  logic               keep_left;

  // Equal priorities stay ahead of the new entry (FIFO among equals).
  assign keep_self = occ_self && (prio_r <= new_prio);
  assign keep_left = occ_left && (left_prio <= new_prio);

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.enq) begin
      if (keep_self) begin
        value_nxt = value_r;
        prio_nxt  = prio_r;
      end else if (keep_left) begin
        value_nxt = new_value;
        prio_nxt  = new_prio;
      end else begin
        value_nxt = left_value;
        prio_nxt  = left_prio;
      end
    end else if (cmd.deq) begin
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value = value_r;
  assign prio  = prio_r;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Stable priority queue: a row of sorted cells that shift on insert and remove.
// The cells update on the input transfer; the snapshot stage then registers the result.
// The input takes no new operation while one is pending in the snapshot stage behind the cell row.
// The input waits while a result is held and its output transfer has not happened.
// Synchronous active-low reset empties the queue and drops any pending result.
`timescale 1ns / 1ps
module stable_priority_queue #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  spq_in_if.sink        in_ch,
  spq_out_if.source     out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PW    = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pend_r;
  spq_status_t         status_r, status_nxt;
  logic                out_valid_r;
  spq_status_t         out_status_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_empty_r;
  logic [VALUE_W-1:0]  out_hv_r, out_tv_r;
  logic [PRIO_W-1:0]   out_hp_r, out_tp_r;

  logic                accept;
  logic                full;
  spq_cmd_t            cmd;
  logic [PW-1:0]       new_prio;
  logic [VALUE_W-1:0]  cell_val [CAPACITY];
  logic [PW-1:0]       cell_pri [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [IDX_W-1:0]    tail_idx;

  assign in_ch.ready = !pend_r && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CNT_W'(CAPACITY));
  assign new_prio    = in_ch.prio[PW-1:0];
  assign tail_idx    = IDX_W'(cnt_r - CNT_W'(1));

  always_comb begin
    cmd        = '0;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    if (accept) begin
      unique case (in_ch.opcode)
        OP_ENQ: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.enq = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        OP_DEQ: begin
          if (cnt_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.deq = 1'b1;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        OP_CLR: begin
          cnt_nxt = '0;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               occ_left;
    logic [VALUE_W-1:0] left_value, right_value;
    logic [PW-1:0]      left_prio, right_prio;

    assign occ[g] = (cnt_r > CNT_W'(g));

    if (g == 0) begin : g_first
      // Head cell sees a left neighbor that always stays put.
      assign occ_left   = 1'b1;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_mid
      assign occ_left   = occ[g-1];
      assign left_value = cell_val[g-1];
      assign left_prio  = cell_pri[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_inner
      assign right_value = cell_val[g+1];
      assign right_prio  = cell_pri[g+1];
    end

    spq_cell #(.PW(PW)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ_self   (occ[g]),
      .occ_left   (occ_left),
      .new_value  (in_ch.value),
      .new_prio   (new_prio),
      .left_value (left_value),
      .left_prio  (left_prio),
      .right_value(right_value),
      .right_prio (right_prio),
      .value      (cell_val[g]),
      .prio       (cell_pri[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= accept;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    // Snapshot the row while pend_r is set, once the cells have settled.
    if (pend_r) begin
      out_status_r <= status_r;
      out_count_r  <= cnt_r;
      out_empty_r  <= (cnt_r == '0);
      if (cnt_r == '0) begin
        out_hv_r <= '0;
        out_hp_r <= '0;
        out_tv_r <= '0;
        out_tp_r <= '0;
      end else begin
        out_hv_r <= cell_val[0];
        out_hp_r <= PRIO_W'(cell_pri[0]);
        out_tv_r <= cell_val[tail_idx];
        out_tp_r <= PRIO_W'(cell_pri[tail_idx]);
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.is_empty   = out_empty_r;
  assign out_ch.head_value = out_hv_r;
  assign out_ch.head_prio  = out_hp_r;
  assign out_ch.tail_value = out_tv_r;
  assign out_ch.tail_prio  = out_tp_r;

endmodule
